>>> sv/lta_pkg.sv
// shared types and codes for the lru tile allocator
`default_nettype none

package lta_pkg;

  localparam int unsigned IdxBits  = 8;
  localparam int unsigned CntBits  = 9;
  localparam int unsigned FrmBits  = 32;
  localparam int unsigned OwnBits  = 16;

  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_FREE     = 3'd1;
  localparam logic [2:0] CMD_FREE_ALL = 3'd2;
  localparam logic [2:0] CMD_TOUCH    = 3'd3;
  localparam logic [2:0] CMD_BEGIN    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // search token passed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               free_hit;
    logic [IdxBits-1:0] free_idx;
    logic               old_hit;
    logic [FrmBits-1:0] old_frame;
    logic [IdxBits-1:0] old_idx;
    logic [CntBits-1:0] cnt;
  } lta_tok_t;

  // update broadcast to every cell
  typedef struct packed {
    logic               free_all;
    logic               free_en;
    logic               touch_en;
    logic               grant_en;
    logic [IdxBits-1:0] idx;
    logic [OwnBits-1:0] owner;
    logic [FrmBits-1:0] frame;
  } lta_ctl_t;

endpackage

`default_nettype wire

>>> sv/lru_tile_allocator_unit.sv
// lru tile allocator top level: command sequencer, tile cell chain, result register
//
// Takes one command beat on s_axis and returns one result beat on m_axis.
// Commands: allocate, free tile, free all, touch tile, begin frame.
// Every command, after its direct update, sends a search token down a chain
// of TILES_PER_ROW*TILES_PER_ROW tile cells, one cell per cycle, collecting
// the busy count, the lowest free tile and the oldest tile before the
// current frame; an allocate then writes the chosen cell.
// After the command beat the sequencer steps through the update, launch,
// scan and done states, the scan set by the length of the cell chain; one
// command is in flight at a time, so the next command beat is taken only
// after the last result has been loaded into the output register.
// s_axis_tready is high while the sequencer is idle, also while a result
// beat waits in the output register; a stalled receiver holds the result
// and the next command waits before its result is written.
// Reset (rst_ni low, asynchronous) frees every tile, zeroes the last-use
// frames and the current frame, and empties the output register.
`default_nettype none

module lru_tile_allocator_unit #(
  parameter int unsigned TILES_PER_ROW = 8,
  parameter int unsigned TILE_EDGE     = 512,
  parameter int unsigned OWNER_BITS    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], requested_size[18:3], owner_id[34:19], tile_index[42:35],
  // frame_number[74:43], zero fill
  input  wire  [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[1:0], granted_tile[7:2], allocated_count[14:8], zero fill
  output logic [15:0] m_axis_tdata
);
  import lta_pkg::*;

  localparam int unsigned TileCount = TILES_PER_ROW * TILES_PER_ROW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [2:0]          cmd_q;
  logic [15:0]         req_q;
  logic [OwnBits-1:0]  owner_q;
  logic [IdxBits-1:0]  idx_q;
  logic [FrmBits-1:0]  frame_q;
  logic [FrmBits-1:0]  cur_frame_q;
  logic [1:0]          res_status_q, res_status_d;
  logic [5:0]          res_tile_q, res_tile_d;
  logic [6:0]          res_cnt_q, res_cnt_d;
  logic                out_vld_q;
  logic [15:0]         out_data_q;
  logic                in_acc;
  logic                out_free;
  logic                range_err;
  logic [10:0]         edge_w;
  logic                fit;
  logic                grant;
  logic [IdxBits-1:0]  grant_idx;
  logic [CntBits-1:0]  cnt_after;
  lta_ctl_t            ctl;
  lta_tok_t            tok_start;
  lta_tok_t            tok [TileCount+1];
  lta_tok_t            tok_end;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign range_err = ({1'b0, idx_q} >= CntBits'(TileCount));

  always_comb begin
    priority if (req_q <= 16'd256) begin
      edge_w = 11'd256;
    end else if (req_q <= 16'd512) begin
      edge_w = 11'd512;
    end else begin
      edge_w = 11'd1024;
    end
  end

  assign fit       = (32'(TILE_EDGE) >= {21'b0, edge_w});
  assign tok_end   = tok[TileCount];
  assign grant     = tok_end.vld && (cmd_q == CMD_ALLOC) && fit &&
                     (tok_end.free_hit || tok_end.old_hit);
  assign grant_idx = tok_end.free_hit ? tok_end.free_idx : tok_end.old_idx;
  assign cnt_after = tok_end.cnt + CntBits'(grant && tok_end.free_hit);

  always_comb begin
    ctl          = '0;
    ctl.idx      = (state_q == S_SCAN) ? grant_idx : idx_q;
    ctl.owner    = owner_q;
    ctl.frame    = cur_frame_q;
    if (state_q == S_UPD) begin
      ctl.free_all = (cmd_q == CMD_FREE_ALL);
      ctl.free_en  = (cmd_q == CMD_FREE) && !range_err;
      ctl.touch_en = (cmd_q == CMD_TOUCH) && !range_err;
    end
    if (state_q == S_SCAN) begin
      ctl.grant_en = grant;
    end
  end

  always_comb begin
    tok_start           = '0;
    tok_start.vld       = (state_q == S_LAUNCH);
    tok_start.old_frame = cur_frame_q;
  end

  assign tok[0] = tok_start;

  for (genvar i = 0; i < TileCount; i++) begin : g_cell
    lta_cell #(
      .Idx       (i),
      .OwnerBits (OWNER_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_comb begin
    res_status_d = ST_OK;
    if (((cmd_q == CMD_FREE) || (cmd_q == CMD_TOUCH)) && range_err) begin
      res_status_d = ST_RANGE;
    end else if ((cmd_q == CMD_ALLOC) && !grant) begin
      res_status_d = ST_NOFIT;
    end
    res_tile_d = grant ? grant_idx[5:0] : 6'd0;
    res_cnt_d  = cnt_after[6:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_UPD;
      S_UPD:    state_d = S_LAUNCH;
      S_LAUNCH: state_d = S_SCAN;
      S_SCAN:   if (tok_end.vld) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_frame_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_UPD) && (cmd_q == CMD_BEGIN)) begin
        cur_frame_q <= frame_q;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= s_axis_tdata[2:0];
      req_q   <= s_axis_tdata[18:3];
      owner_q <= s_axis_tdata[34:19];
      idx_q   <= s_axis_tdata[42:35];
      frame_q <= s_axis_tdata[74:43];
    end
    if ((state_q == S_SCAN) && tok_end.vld) begin
      res_status_q <= res_status_d;
      res_tile_q   <= res_tile_d;
      res_cnt_q    <= res_cnt_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_data_q <= {1'b0, res_cnt_q, res_tile_q, res_status_q};
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_UPD))
    else $error("accepted command did not start its update");

  a_token_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.vld |-> (state_q == S_SCAN))
    else $error("search token left the chain outside the scan");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.vld |-> (cnt_after <= CntBits'(TileCount)))
    else $error("busy count exceeds the tile count");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_free) |=> (out_vld_q && (state_q == S_IDLE)))
    else $error("finished command did not produce a result beat");
`endif

endmodule

`default_nettype wire

>>> sv/lta_cell.sv
// one tile entry of the allocator chain with its search stage
`default_nettype none

module lta_cell #(
  parameter int unsigned Idx       = 0,
  parameter int unsigned OwnerBits = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  lta_pkg::lta_ctl_t  ctl_i,
  input  lta_pkg::lta_tok_t  tok_i,
  output lta_pkg::lta_tok_t  tok_o
);
  import lta_pkg::*;

  logic                   busy_q;
  logic [OwnerBits-1:0]   owner_q;
  logic [FrmBits-1:0]     last_q;
  logic                   sel;
  logic [OwnerBits+OwnBits-1:0] own_ext;
  logic                   vld_q;
  lta_tok_t               tok_d;
  lta_tok_t               tok_q;

  assign sel     = (ctl_i.idx == IdxBits'(Idx));
  assign own_ext = {{OwnerBits{1'b0}}, ctl_i.owner};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      last_q <= '0;
    end else if (ctl_i.free_all || (ctl_i.free_en && sel)) begin
      busy_q <= 1'b0;
      last_q <= '0;
    end else if (ctl_i.grant_en && sel) begin
      busy_q <= 1'b1;
      last_q <= ctl_i.frame;
    end else if (ctl_i.touch_en && sel) begin
      last_q <= ctl_i.frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.grant_en && sel) begin
      owner_q <= own_ext[OwnerBits-1:0];
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (busy_q) begin
      tok_d.cnt = tok_i.cnt + CntBits'(1);
    end
    if (!busy_q && !tok_i.free_hit) begin
      tok_d.free_hit = 1'b1;
      tok_d.free_idx = IdxBits'(Idx);
    end
    if (last_q < tok_i.old_frame) begin
      tok_d.old_hit   = 1'b1;
      tok_d.old_frame = last_q;
      tok_d.old_idx   = IdxBits'(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

`default_nettype wire
